// ----- rtl/core/pli_pkg.sv -----
// Shared types, codes and defaults for the positional list block.
package pli_pkg;

    localparam int CAPACITY_DEF   = 16;
    localparam int DATA_WIDTH_DEF = 32;

    localparam int POS_W    = 5;
    localparam int VALUE_W  = 32;
    localparam int STATUS_W = 2;
    localparam int LENGTH_W = 5;

    localparam logic CMD_INSERT = 1'b0;
    localparam logic CMD_DELETE = 1'b1;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_RANGE = 2'd1,
        ST_EMPTY = 2'd2,
        ST_FULL  = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_EXEC = 3'b010,
        S_RESP = 3'b100
    } state_t;

    // controller to datapath
    typedef struct packed {
        logic load_req;
        logic exec;
    } ctrl_cmd_t;

endpackage

// ----- rtl/core/pli_ctrl.sv -----
// Controller state machine: request capture, execute step and result hand-off.
module pli_ctrl
    import pli_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    output logic      m_valid,
    input  logic      m_ready,
    output ctrl_cmd_t cmd
);

    state_t state_reg, state_next;

    assign s_ready      = (state_reg == S_IDLE) || ((state_reg == S_RESP) && m_ready);
    assign m_valid      = (state_reg == S_RESP);
    assign cmd.load_req = s_valid && s_ready;
    assign cmd.exec     = (state_reg == S_EXEC);

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE: begin
                if (s_valid) state_next = S_EXEC;
            end
            S_EXEC: begin
                state_next = S_RESP;
            end
            S_RESP: begin
                // a new request may be taken in the cycle the result leaves
                if (m_ready) state_next = s_valid ? S_EXEC : S_IDLE;
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) state_reg <= S_IDLE;
        else          state_reg <= state_next;
    end

endmodule

// ----- rtl/core/pli_datapath.sv -----
// Datapath: row of shift cells, element count, request and result registers.
module pli_datapath
    import pli_pkg::*;
#(
    parameter int CAPACITY   = CAPACITY_DEF,
    parameter int DATA_WIDTH = DATA_WIDTH_DEF
)(
    input  logic                aclk,
    input  logic                aresetn,
    input  ctrl_cmd_t           cmd,
    input  logic                s_cmd,
    input  logic [POS_W-1:0]    s_position,
    input  logic [VALUE_W-1:0]  s_value,
    output logic [STATUS_W-1:0] m_status,
    output logic [VALUE_W-1:0]  m_removed_value,
    output logic [LENGTH_W-1:0] m_length,
    output logic                m_empty_res
);

    localparam int NW = $clog2(CAPACITY + 1);
    localparam int IW = $clog2(CAPACITY);
    // compare width: holds position, count and count + 1
    localparam int CW = (NW > POS_W) ? NW + 1 : POS_W + 1;

    logic                  op_reg;
    logic [POS_W-1:0]      pos_reg;
    logic [DATA_WIDTH-1:0] val_reg;

    logic [DATA_WIDTH-1:0] cell_reg  [CAPACITY];
    logic [DATA_WIDTH-1:0] cell_next [CAPACITY];
    logic [NW-1:0]         count_reg, count_next;

    status_t               status_reg, status_next;
    logic [VALUE_W-1:0]    removed_reg, removed_next;

    logic [CW-1:0] pos_w, cnt_w, p0;
    logic [63:0]   val_ext, rem_ext;
    logic          ins_ok, del_ok;

    assign val_ext = 64'(s_value);
    assign pos_w   = CW'(pos_reg);
    assign cnt_w   = CW'(count_reg);
    assign p0      = pos_w - CW'(1);
    assign rem_ext = 64'(cell_reg[p0[IW-1:0]]);

    always_comb begin
        status_next  = ST_OK;
        removed_next = '0;
        count_next   = count_reg;
        ins_ok       = 1'b0;
        del_ok       = 1'b0;
        if (op_reg == CMD_INSERT) begin
            if (cnt_w >= CW'(CAPACITY))                    status_next = ST_FULL;
            else if (pos_w == '0 || pos_w > cnt_w + CW'(1)) status_next = ST_RANGE;
            else begin
                ins_ok     = 1'b1;
                count_next = count_reg + NW'(1);
            end
        end else begin
            if (count_reg == '0)                     status_next = ST_EMPTY;
            else if (pos_w == '0 || pos_w > cnt_w)   status_next = ST_RANGE;
            else begin
                del_ok       = 1'b1;
                removed_next = rem_ext[VALUE_W-1:0];
                count_next   = count_reg - NW'(1);
            end
        end
    end

    // each cell takes its neighbour, the new value, or holds
    always_comb begin
        for (int i = 0; i < CAPACITY; i++) begin
            cell_next[i] = cell_reg[i];
            if (ins_ok) begin
                if (CW'(i) == p0)                 cell_next[i] = val_reg;
                else if (CW'(i) > p0 && i > 0)    cell_next[i] = cell_reg[(i > 0) ? i - 1 : 0];
            end else if (del_ok) begin
                if (CW'(i) >= p0 && i < CAPACITY - 1)
                    cell_next[i] = cell_reg[(i < CAPACITY - 1) ? i + 1 : i];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_req) begin
            op_reg  <= s_cmd;
            pos_reg <= s_position;
            val_reg <= val_ext[DATA_WIDTH-1:0];
        end
        if (cmd.exec) begin
            status_reg  <= status_next;
            removed_reg <= removed_next;
            for (int i = 0; i < CAPACITY; i++) cell_reg[i] <= cell_next[i];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn)      count_reg <= '0;
        else if (cmd.exec) count_reg <= count_next;
    end

    assign m_status        = status_reg;
    assign m_removed_value = removed_reg;
    assign m_length        = LENGTH_W'(count_reg);
    assign m_empty_res     = (count_reg == '0);

endmodule

// ----- rtl/core/positional_list_insert_delete_top.sv -----
// Top level of the positional list: controller and datapath.
//
// Keeps an ordered list of up to CAPACITY values. Each request on the s_
// channel is an insert (s_cmd 0) of s_value at 1-based s_position, or a
// delete (s_cmd 1) of the element at s_position. Each request gives exactly
// one result on the m_ channel: status, removed value, new length and an
// empty flag.
// After the edge that accepts a request the controller passes through its execute
// state, where the list is updated, and then raises m_valid in its result state.
// The next request is taken in the same cycle the previous result is taken, so a
// new request can be accepted as a result leaves but not while one executes. The
// shift of all cells happens in the execute state, so the request rate is set
// by the capture/execute/result sequence of the controller.
// Reset (aresetn low, synchronous) empties the list and clears the
// controller; stored values are not cleared and are never visible.
// If the receiver stalls, the result is held on m_ with m_valid high and no
// further request is executed until it is taken.
module positional_list_insert_delete_top
    import pli_pkg::*;
#(
    parameter int CAPACITY   = CAPACITY_DEF,
    parameter int DATA_WIDTH = DATA_WIDTH_DEF
)(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic                s_cmd,
    input  logic [POS_W-1:0]    s_position,
    input  logic [VALUE_W-1:0]  s_value,
    output logic                m_valid,
    input  logic                m_ready,
    output logic [STATUS_W-1:0] m_status,
    output logic [VALUE_W-1:0]  m_removed_value,
    output logic [LENGTH_W-1:0] m_length,
    output logic                m_empty_res
);

    ctrl_cmd_t cmd;

    pli_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .cmd     (cmd)
    );

    pli_datapath #(
        .CAPACITY   (CAPACITY),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_datapath (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cmd             (cmd),
        .s_cmd           (s_cmd),
        .s_position      (s_position),
        .s_value         (s_value),
        .m_status        (m_status),
        .m_removed_value (m_removed_value),
        .m_length        (m_length),
        .m_empty_res     (m_empty_res)
    );

endmodule

// ----- bench/pli_list_scoreboard_pkg.sv -----
// Scoreboard for the positional list bench: list predictor and result checker.
`timescale 1ns / 100ps

package pli_list_scoreboard_pkg;

    import pli_pkg::*;

    typedef struct {
        status_t              status;
        logic [VALUE_W-1:0]   removed;
        logic [LENGTH_W-1:0]  length;
        logic                 empty;
    } list_result_t;

    class pli_list_scoreboard;

        int unsigned          capacity;
        logic [VALUE_W-1:0]   contents[$];
        list_result_t         awaited[$];
        int unsigned          mismatches;

        function new(int unsigned cap);
            capacity   = cap;
            mismatches = 0;
        endfunction

        function int unsigned list_length();
            return contents.size();
        endfunction

        function int unsigned outstanding();
            return awaited.size();
        endfunction

        // Apply an accepted request to the shadow list and queue its result.
        function void note_request(logic cmd, logic [POS_W-1:0] pos, logic [VALUE_W-1:0] val);
            list_result_t res;
            int unsigned  len;
            len         = contents.size();
            res.status  = ST_OK;
            res.removed = '0;
            if (cmd == CMD_INSERT) begin
                // fullness is checked before the position
                if (len >= capacity) begin
                    res.status = ST_FULL;
                end else if (pos < 1 || pos > len + 1) begin
                    res.status = ST_RANGE;
                end else begin
                    contents.insert(pos - 1, val);
                end
            end else begin
                if (len == 0) begin
                    res.status = ST_EMPTY;
                end else if (pos < 1 || pos > len) begin
                    res.status = ST_RANGE;
                end else begin
                    res.removed = contents[pos - 1];
                    contents.delete(pos - 1);
                end
            end
            res.length = LENGTH_W'(contents.size());
            res.empty  = (contents.size() == 0);
            awaited.push_back(res);
        endfunction

        task report_mismatch(string what, logic [VALUE_W-1:0] got, logic [VALUE_W-1:0] want);
            mismatches++;
            $display("%0t mismatch on %s: got %0h, expected %0h", $realtime, what, got, want);
        endtask

        task check_result(logic [STATUS_W-1:0] status, logic [VALUE_W-1:0] removed,
                          logic [LENGTH_W-1:0] len, logic empty);
            list_result_t want;
            if (awaited.size() == 0) begin
                report_mismatch("result with no request outstanding", status, 0);
                return;
            end
            want = awaited.pop_front();
            if (status !== want.status)
                report_mismatch("status", status, want.status);
            if (removed !== want.removed)
                report_mismatch("removed_value", removed, want.removed);
            if (len !== want.length)
                report_mismatch("length", len, want.length);
            if (empty !== want.empty)
                report_mismatch("empty_res", empty, want.empty);
        endtask

    endclass

endpackage

// ----- bench/testbench.sv -----
// Top of the positional list bench: clock, reset, request driver, result taker.
`timescale 1ns / 100ps

module testbench;

    import pli_pkg::*;
    import pli_list_scoreboard_pkg::*;

    localparam int unsigned WATCHDOG_LIMIT = 2000;
    localparam int unsigned RANDOM_PER_PHASE = 220;

    logic                aclk       = 1'b0;
    logic                aresetn    = 1'b0;
    logic                s_valid    = 1'b0;
    logic                s_ready;
    logic                s_cmd      = CMD_INSERT;
    logic [POS_W-1:0]    s_position = '0;
    logic [VALUE_W-1:0]  s_value    = '0;
    logic                m_valid;
    logic                m_ready    = 1'b0;
    logic [STATUS_W-1:0] m_status;
    logic [VALUE_W-1:0]  m_removed_value;
    logic [LENGTH_W-1:0] m_length;
    logic                m_empty_res;

    pli_list_scoreboard  sb;
    int unsigned         send_idle_pct = 0;
    int unsigned         take_stall_pct = 0;
    int unsigned         quiet_cycles = 0;
    bit                  grow_list = 1'b1;

    positional_list_insert_delete_top DUT (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_cmd           (s_cmd),
        .s_position      (s_position),
        .s_value         (s_value),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_status        (m_status),
        .m_removed_value (m_removed_value),
        .m_length        (m_length),
        .m_empty_res     (m_empty_res)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    // result side: take and check, then pick next cycle's ready
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready)
            sb.check_result(m_status, m_removed_value, m_length, m_empty_res);
        m_ready <= (take_stall_pct == 0) || ($urandom_range(99) >= take_stall_pct);
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // Present one request, hold it until accepted, then log it.
    task automatic send_request(logic cmd, logic [POS_W-1:0] pos, logic [VALUE_W-1:0] val);
        if (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(99) < send_idle_pct);
        end
        s_valid    <= 1'b1;
        s_cmd      <= cmd;
        s_position <= pos;
        s_value    <= val;
        do @(posedge aclk); while (s_ready !== 1'b1);
        sb.note_request(cmd, pos, val);
    endtask

    task automatic random_request();
        logic               cmd;
        logic [POS_W-1:0]   pos;
        logic [VALUE_W-1:0] val;
        int unsigned        len;
        len = sb.list_length();
        // sweep the list between empty and full so both ends get exercised
        if (len >= CAPACITY_DEF)
            grow_list = 1'b0;
        else if (len == 0)
            grow_list = 1'b1;
        cmd = ($urandom_range(99) < (grow_list ? 70 : 30)) ? CMD_INSERT : CMD_DELETE;
        if ($urandom_range(99) < 15 || (cmd == CMD_DELETE && len == 0))
            pos = POS_W'($urandom_range(31, 0));
        else if (cmd == CMD_INSERT)
            pos = POS_W'($urandom_range(len + 1, 1));
        else
            pos = POS_W'($urandom_range(len, 1));
        case ($urandom_range(9))
            0:       val = '0;
            1:       val = '1;
            default: val = $urandom;
        endcase
        send_request(cmd, pos, val);
    endtask

    initial begin
        sb = new(CAPACITY_DEF);
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: empty, range and full cases, both ends of the list
        send_request(CMD_DELETE, 5'd1, 32'h0);
        send_request(CMD_DELETE, 5'd0, 32'h0);
        send_request(CMD_INSERT, 5'd0, 32'h1111_1111);
        send_request(CMD_INSERT, 5'd2, 32'h2222_2222);
        send_request(CMD_INSERT, 5'd1, 32'h0000_0000);
        send_request(CMD_INSERT, 5'd2, 32'hFFFF_FFFF);
        send_request(CMD_INSERT, 5'd1, 32'hA5A5_A5A5);
        send_request(CMD_INSERT, 5'd2, 32'h5A5A_5A5A);
        while (sb.list_length() < CAPACITY_DEF)
            send_request(CMD_INSERT, POS_W'($urandom_range(sb.list_length() + 1, 1)), $urandom);
        send_request(CMD_INSERT, 5'd31, 32'hFFFF_FFFF);
        send_request(CMD_INSERT, 5'd1, 32'h1234_5678);
        send_request(CMD_DELETE, 5'd0, 32'hFFFF_FFFF);
        send_request(CMD_DELETE, 5'd17, 32'h0);
        send_request(CMD_DELETE, 5'd16, 32'h0);
        send_request(CMD_DELETE, 5'd1, 32'h0);
        send_request(CMD_DELETE, 5'd31, 32'h0);

        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin send_idle_pct = 0;  take_stall_pct = 0;  end
                1: begin send_idle_pct = 76; take_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  take_stall_pct = 76; end
                default: begin send_idle_pct = 7; take_stall_pct = 7; end
            endcase
            repeat (RANDOM_PER_PHASE) random_request();
        end

        s_valid <= 1'b0;
        while (sb.outstanding() != 0)
            @(posedge aclk);
        repeat (10) @(posedge aclk);
        if (sb.mismatches == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

// ----- filelist.f -----
rtl/core/pli_pkg.sv
rtl/core/pli_ctrl.sv
rtl/core/pli_datapath.sv
rtl/core/positional_list_insert_delete_top.sv
bench/pli_list_scoreboard_pkg.sv
bench/testbench.sv
